@@ rtl/core/mvr_pkg.sv @@
// mvr_pkg: shared types and constants for the mean and variance reduction block
// no dependencies; imported by every module in rtl/core
package mvr_pkg;

    // default parameter values
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_COUNT_BITS  = 16;

    // fixed field widths
    localparam int MEAN_W = 16;
    localparam int VAR_W  = 32;
    localparam int GL_W   = 16;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_GROUP_LENGTH = 2'b00;
    localparam logic [GL_W-1:0] GROUP_LENGTH_RESET = 16'd1;

    // accumulator control from the sequencer
    typedef struct packed {
        logic accumulate;
        logic clear;
    } acc_ctrl_t;

endpackage

@@ rtl/core/mvr_accum.sv @@
// mvr_accum: running sum, sum of squares and sample count for one group
// depends on mvr_pkg (acc_ctrl_t)
module mvr_accum #(
    parameter int SAMPLE_BITS = mvr_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = mvr_pkg::DEF_COUNT_BITS,
    parameter int SUM_W       = SAMPLE_BITS + COUNT_BITS,
    parameter int SQ_W        = 2 * SAMPLE_BITS + COUNT_BITS - 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mvr_pkg::acc_ctrl_t            ctrl,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [COUNT_BITS-1:0]         eff_len,
    output logic signed [SUM_W-1:0]       sum,
    output logic [SQ_W-1:0]               sq_sum,
    output logic [COUNT_BITS-1:0]         count,
    output logic                          last
);
    import mvr_pkg::*;

    logic signed [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic [COUNT_BITS-1:0]      count_reg;
    logic [SAMPLE_BITS-1:0]     mag;
    logic [2*SAMPLE_BITS-1:0]   square;
    logic [COUNT_BITS-1:0]      count_inc;

    // magnitude and square of the incoming sample
    assign mag    = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample + 1'b1)
                                          : SAMPLE_BITS'(sample);
    assign square = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);

    // group ends once the count reaches the effective length
    assign count_inc = count_reg + 1'b1;
    assign last      = (count_inc >= eff_len);

    // accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            sq_reg    <= '0;
            count_reg <= '0;
        end else if (ctrl.clear) begin
            sum_reg   <= '0;
            sq_reg    <= '0;
            count_reg <= '0;
        end else if (ctrl.accumulate) begin
            sum_reg   <= sum_reg + SUM_W'(sample);
            sq_reg    <= sq_reg + SQ_W'(square);
            count_reg <= count_inc;
        end
    end

    assign sum    = sum_reg;
    assign sq_sum = sq_reg;
    assign count  = count_reg;

endmodule

@@ rtl/core/mvr_divider.sv @@
// mvr_divider: shared restoring divider, one quotient bit per cycle
// depends on mvr_pkg; used twice per group for the mean and the mean square
module mvr_divider #(
    parameter int DIVIDEND_W = 47,
    parameter int DIVISOR_W  = mvr_pkg::DEF_COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);
    import mvr_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quot_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_diff;
    logic                  fits;

    // one restoring step
    assign trial      = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign fits       = (trial >= {1'b0, div_reg});

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[DIVIDEND_W-2:0], fits};
            rem_reg  <= fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

@@ rtl/core/mean_variance_reduction_top.sv @@
// mean_variance_reduction_top: streaming mean and variance over groups of samples
// depends on mvr_pkg, mvr_accum and mvr_divider
//
// Usage
//   s_ channel: one signed Q8.8 sample per transaction (s_valid / s_ready).
//   m_ channel: one mean (Q8.8) and variance (Q16.16) per group (m_valid / m_ready).
//   APB port: register 0 at byte address 0 holds group_length (0 acts as 1).
// Flow
//   Samples that do not close a group are taken back to back while the
//   sequencer is idle. The sample that closes a group starts the shared
//   divider twice, sum / count and then square sum / count, one quotient bit
//   per cycle, and the input is held off until the result is handed on; the
//   divider is 47 bits wide at default parameters.
//   The variance subtract, clamp and saturate run combinationally in the result state.
// Reset
//   aresetn is synchronous and active low; it clears the accumulators, the
//   sequencer and the output valid, and sets group_length to 1.
// Backpressure
//   The result sits in an output register; the next group's samples are taken
//   while it waits. A second result waits in the sequencer until m_ready
//   frees the output register.
module mean_variance_reduction_top #(
    parameter int SAMPLE_BITS = mvr_pkg::DEF_SAMPLE_BITS,
    parameter int COUNT_BITS  = mvr_pkg::DEF_COUNT_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // sample input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [mvr_pkg::MEAN_W-1:0] m_mean,
    output logic [mvr_pkg::VAR_W-1:0]         m_variance,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mvr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mvr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [mvr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import mvr_pkg::*;

    localparam int SUM_W   = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_FULL = 2 * SAMPLE_BITS + COUNT_BITS - 1;
    localparam int SQ_W    = (SQ_FULL > 64) ? 64 : SQ_FULL;
    localparam int LEN_W   = (COUNT_BITS > GL_W) ? COUNT_BITS : GL_W;
    localparam int VX_W    = (SQ_W > VAR_W) ? SQ_W : VAR_W;
    localparam int MEXT_W  = (SAMPLE_BITS + 1 > MEAN_W) ? SAMPLE_BITS + 1 : MEAN_W;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_START    = 5'b00010,
        ST_DIV_MEAN = 5'b00100,
        ST_DIV_SQ   = 5'b01000,
        ST_RESULT   = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [GL_W-1:0]            group_length_reg;
    logic                       neg_reg;
    logic [SAMPLE_BITS-1:0]     mean_mag_reg;
    logic [2*SAMPLE_BITS-1:0]   m2_reg;
    logic                       m_valid_reg;
    logic [MEAN_W-1:0]          m_mean_reg;
    logic [VAR_W-1:0]           m_variance_reg;

    acc_ctrl_t                  acc_ctrl;
    logic signed [SUM_W-1:0]    acc_sum;
    logic [SQ_W-1:0]            acc_sq;
    logic [COUNT_BITS-1:0]      acc_count;
    logic                       acc_last;
    logic [LEN_W-1:0]           len_ext;
    logic [LEN_W-1:0]           len_cap;
    logic [LEN_W-1:0]           len_eff;
    logic [COUNT_BITS-1:0]      eff_len;

    logic                       div_start;
    logic [SQ_W-1:0]            div_dividend;
    logic [SQ_W-1:0]            div_quotient;
    logic                       div_done;
    logic [SUM_W-1:0]           sum_mag;

    logic                       s_fire;
    logic                       out_free;
    logic [SQ_W-1:0]            m2_ext;
    logic [SQ_W-1:0]            var_full;
    logic [VX_W-1:0]            var_x;
    logic [VAR_W-1:0]           var_sat;
    logic [MEXT_W-1:0]          mean_pos;
    logic [MEXT_W-1:0]          mean_ext;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_length_reg <= GROUP_LENGTH_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_GROUP_LENGTH)) begin
            group_length_reg <= pwdata[GL_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_GROUP_LENGTH) ? APB_DATA_W'(group_length_reg) : '0;

    // effective group length: zero acts as one, saturate at counter range
    assign len_ext = LEN_W'(group_length_reg);
    assign len_cap = LEN_W'({COUNT_BITS{1'b1}});
    assign len_eff = (len_ext == '0)     ? LEN_W'(1) :
                     (len_ext > len_cap) ? len_cap   : len_ext;
    assign eff_len = len_eff[COUNT_BITS-1:0];

    // handshake
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // accumulators
    assign acc_ctrl.accumulate = s_fire;
    assign acc_ctrl.clear      = (state_reg == ST_DIV_MEAN) && div_done;

    mvr_accum #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .SUM_W       (SUM_W),
        .SQ_W        (SQ_W)
    ) u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (acc_ctrl),
        .sample  (s_sample),
        .eff_len (eff_len),
        .sum     (acc_sum),
        .sq_sum  (acc_sq),
        .count   (acc_count),
        .last    (acc_last)
    );

    // shared divider: |sum| first, then the square sum, both over the
    // sample count of the closing group
    assign sum_mag      = acc_sum[SUM_W-1] ? SUM_W'(~acc_sum + 1'b1) : SUM_W'(acc_sum);
    assign div_start    = (state_reg == ST_START) ||
                          ((state_reg == ST_DIV_MEAN) && div_done);
    assign div_dividend = (state_reg == ST_START) ? SQ_W'(sum_mag) : acc_sq;

    mvr_divider #(
        .DIVIDEND_W (SQ_W),
        .DIVISOR_W  (COUNT_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (acc_count),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && acc_last) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_DIV_MEAN;
            end
            ST_DIV_MEAN: begin
                if (div_done) begin
                    state_next = ST_DIV_SQ;
                end
            end
            ST_DIV_SQ: begin
                if (div_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sign, mean magnitude and mean squared
    always_ff @(posedge aclk) begin
        if (state_reg == ST_START) begin
            neg_reg <= acc_sum[SUM_W-1];
        end
        if ((state_reg == ST_DIV_MEAN) && div_done) begin
            mean_mag_reg <= div_quotient[SAMPLE_BITS-1:0];
        end
        if (state_reg == ST_DIV_SQ) begin
            m2_reg <= (2*SAMPLE_BITS)'(mean_mag_reg) * (2*SAMPLE_BITS)'(mean_mag_reg);
        end
    end

    // variance: clamp at zero, saturate to 32 bits
    assign m2_ext   = SQ_W'(m2_reg);
    assign var_full = (div_quotient > m2_ext) ? (div_quotient - m2_ext) : '0;
    assign var_x    = VX_W'(var_full);
    assign var_sat  = (var_x > VX_W'({VAR_W{1'b1}})) ? {VAR_W{1'b1}} : var_x[VAR_W-1:0];

    // signed mean from sign and magnitude
    assign mean_pos = MEXT_W'(mean_mag_reg);
    assign mean_ext = neg_reg ? (~mean_pos + 1'b1) : mean_pos;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_RESULT) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_RESULT) && out_free) begin
            m_mean_reg     <= mean_ext[MEAN_W-1:0];
            m_variance_reg <= var_sat;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_mean     = m_mean_reg;
    assign m_variance = m_variance_reg;

endmodule

@@ rtl/core/mvr_checker.sv @@
// mvr_checker: port-level checks for mean_variance_reduction_top
// depends on mvr_pkg; bound to the top level at the end of this file
module mvr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mvr_pkg::MEAN_W-1:0]    m_mean,
    input logic [mvr_pkg::VAR_W-1:0]     m_variance,
    input logic                          pready
);
    import mvr_pkg::*;

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean) && $stable(m_variance))
        else $error("result changed while stalled");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a new result only follows the sequencer, which holds the input off
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without a reduction pass");

    // the configuration port never inserts a wait state
    a_no_wait_states: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("configuration port inserted a wait state");

endmodule

bind mean_variance_reduction_top mvr_checker u_mvr_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_mean     (m_mean),
    .m_variance (m_variance),
    .pready     (pready)
);

@@ tb/mvr_checker.sv @@
// mvr_tb_checker: watches the sample, result and apb channels of the mean and variance block
// predicts each group's mean and variance and compares every result transaction
// depends on mvr_pkg only
`timescale 1ns / 1ps

module mvr_tb_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [15:0]                s_sample,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [mvr_pkg::MEAN_W-1:0] m_mean,
    input  logic [mvr_pkg::VAR_W-1:0]         m_variance,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mvr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [mvr_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic [mvr_pkg::APB_DATA_W-1:0]    prdata,
    input  logic                              pready,
    output int                                mismatches,
    output int                                stats_due,
    output int                                groups_checked
);
    import mvr_pkg::*;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]  variance;
    } mv_stats_t;

    // predictor state
    logic [GL_W-1:0] group_len;
    longint          sum_acc;
    logic [63:0]     square_acc;
    logic [15:0]     count_acc;

    mv_stats_t expected_stats[$];
    mv_stats_t want;
    mv_stats_t folded;

    initial begin
        mismatches     = 0;
        stats_due      = 0;
        groups_checked = 0;
    end

    // fold one sample into the group; returns 1 when the group closes
    function automatic bit fold_sample(input logic signed [15:0] smp, output mv_stats_t res);
        longint      v;
        logic [63:0] mag;
        logic [15:0] limit;
        longint      quot;
        logic [63:0] qmag;
        logic [63:0] mean_sq_avg;
        logic [63:0] mean_of_sq;
        logic [63:0] diff;
        v = smp;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        sum_acc    = sum_acc + v;
        square_acc = square_acc + mag * mag;
        count_acc  = count_acc + 16'd1;
        limit = (group_len == '0) ? 16'd1 : group_len;
        res = '0;
        if (count_acc < limit) begin
            return 1'b0;
        end
        quot = sum_acc / longint'({48'd0, count_acc});
        qmag = (quot < 0) ? 64'(-quot) : 64'(quot);
        mean_sq_avg = square_acc / {48'd0, count_acc};
        mean_of_sq  = qmag * qmag;
        diff = (mean_sq_avg > mean_of_sq) ? (mean_sq_avg - mean_of_sq) : 64'd0;
        if (diff > 64'hFFFF_FFFF) begin
            diff = 64'hFFFF_FFFF;
        end
        res.mean     = quot[MEAN_W-1:0];
        res.variance = diff[VAR_W-1:0];
        sum_acc    = 0;
        square_acc = '0;
        count_acc  = '0;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            group_len  = GROUP_LENGTH_RESET;
            sum_acc    = 0;
            square_acc = '0;
            count_acc  = '0;
            expected_stats.delete();
        end else begin
            // accepted sample transaction
            if (s_valid && s_ready) begin
                if (fold_sample(s_sample, folded)) begin
                    expected_stats.push_back(folded);
                end
            end

            // accepted result transaction
            if (m_valid && m_ready) begin
                if (expected_stats.size() == 0) begin
                    $error("result with no pending expectation: mean %0d variance %0d",
                           $signed(m_mean), m_variance);
                    mismatches++;
                end else begin
                    want = expected_stats.pop_front();
                    groups_checked++;
                    if (m_mean !== want.mean) begin
                        $error("mean mismatch: expected %0d, got %0d",
                               $signed(want.mean), $signed(m_mean));
                        mismatches++;
                    end
                    if (m_variance !== want.variance) begin
                        $error("variance mismatch: expected %0d, got %0d",
                               want.variance, m_variance);
                        mismatches++;
                    end
                end
            end

            // apb register write and readback
            if (psel && penable && pready && (paddr == ADDR_GROUP_LENGTH)) begin
                if (pwrite) begin
                    group_len = pwdata[GL_W-1:0];
                end else if (prdata !== {{(APB_DATA_W-GL_W){1'b0}}, group_len}) begin
                    $error("group_length mismatch: expected %0d, got %0d", group_len, prdata);
                    mismatches++;
                end
            end
        end
        stats_due <= expected_stats.size();
    end

endmodule

@@ tb/tb_mean_variance_reduction_top.sv @@
// tb_mean_variance_reduction_top: stimulus and verdict for mean_variance_reduction_top
// drives samples, backpressure, apb writes and readbacks; mvr_tb_checker does prediction and comparison
`timescale 1ns / 1ps

module tb_mean_variance_reduction_top;
    import mvr_pkg::*;

    localparam int SETTLE_CYCLES   = 150;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SEGMENT_SAMPLES = 48;

    logic                      aclk;
    logic                      aresetn    = 1'b0;
    logic                      s_valid    = 1'b0;
    logic                      s_ready;
    logic signed [15:0]        s_sample   = '0;
    logic                      m_valid;
    logic                      m_ready    = 1'b0;
    logic signed [MEAN_W-1:0]  m_mean;
    logic [VAR_W-1:0]          m_variance;
    logic                      psel       = 1'b0;
    logic                      penable    = 1'b0;
    logic                      pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0]     paddr      = '0;
    logic [APB_DATA_W-1:0]     pwdata     = '0;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    int mismatches;
    int stats_due;
    int groups_checked;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int samples_sent  = 0;
    int quiet_cycles  = 0;
    logic hold_req    = 1'b0;

    mean_variance_reduction_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_mean     (m_mean),
        .m_variance (m_variance),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    mvr_tb_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mean         (m_mean),
        .m_variance     (m_variance),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatches     (mismatches),
        .stats_due      (stats_due),
        .groups_checked (groups_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result receiver: random stalls plus one long hold on request
    initial begin
        wait (aresetn == 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req <= 1'b0;
                m_ready  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // one sample transaction, with random idle cycles ahead of it
    task automatic send_sample(input logic [15:0] v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
    endtask

    // drop valid, wait for every pending result, then let the divider drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (stats_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // apb write of group_length followed by a readback
    task automatic set_group_length(input logic [GL_W-1:0] len);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_GROUP_LENGTH;
        pwdata  <= {16'($urandom), len};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [GL_W-1:0] random_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return GL_W'($urandom_range(9, 40));
            default: return GL_W'($urandom_range(1, 8));
        endcase
    endfunction

    initial begin
        int          eff;
        int          seg_items;
        logic [15:0] edge_vals[7];

        edge_vals = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset length of one, field extremes and bit patterns
        foreach (edge_vals[i]) send_sample(edge_vals[i]);
        wait_idle();

        // pairs: opposite extremes, both negative, mean truncated toward zero
        set_group_length(16'd2);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'hFFFE);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        wait_idle();

        // zero length acts as one
        set_group_length(16'd0);
        send_sample(16'h0100);
        send_sample(16'hFF00);
        wait_idle();

        set_group_length(16'd3);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        wait_idle();

        // length lowered below the samples already in the group
        set_group_length(16'd10);
        repeat (5) send_sample(random_sample());
        wait_idle();
        set_group_length(16'd3);
        send_sample(16'h1234);
        wait_idle();

        // largest length, group closed later by a shorter length
        set_group_length(16'hFFFF);
        repeat (20) send_sample(random_sample());
        wait_idle();
        set_group_length(16'd4);
        send_sample(random_sample());
        wait_idle();

        // random: three backpressure mixes
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 76 : 0;
            recv_idle_pct = (mode == 0) ? 76 : (mode == 1) ? 31 : 0;

            // long receiver hold while samples keep coming
            if (mode == 2) begin
                set_group_length(16'd1);
                hold_req <= 1'b1;
                repeat (40) send_sample(random_sample());
                wait_idle();
            end

            for (int seg = 0; seg < 5; seg++) begin
                set_group_length(random_length());
                eff = (u_checker.group_len == '0) ? 1 : int'(u_checker.group_len);
                seg_items = 0;
                while (seg_items < SEGMENT_SAMPLES) begin
                    repeat (eff) send_sample(random_sample());
                    seg_items += eff;
                end
                // sometimes leave a partial group for the next length to pick up
                if (eff > 1 && $urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, eff - 1)) send_sample(random_sample());
                end
                wait_idle();
            end
        end

        wait_idle();
        $display("sent %0d samples, checked %0d mean/variance results", samples_sent,
                 groups_checked);
        $display("lengths 0 to 65535, mid-group length drops, three stall mixes");
        if (mismatches == 0 && stats_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
